// ===== hdl/rhh_pkg.sv =====
package rhh_pkg;

    localparam int SLOTS      = 256;
    localparam int SLOT_BITS  = $clog2(SLOTS);
    localparam int COUNT_BITS = $clog2(SLOTS + 1);
    localparam int FILL_BITS  = 9;
    localparam int CMP_BITS   = (COUNT_BITS > FILL_BITS) ? COUNT_BITS : FILL_BITS;
    localparam int DATA_BITS  = 32;

    localparam logic [FILL_BITS-1:0] FILL_LIMIT_RESET = FILL_BITS'(230);

    typedef logic [SLOT_BITS-1:0]  t_slot_addr;
    typedef logic [COUNT_BITS-1:0] t_count;
    typedef logic [DATA_BITS-1:0]  t_word;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_FIND   = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        ST_NEW      = 3'd0,
        ST_REPLACED = 3'd1,
        ST_FULL     = 3'd2,
        ST_FOUND    = 3'd3,
        ST_MISSING  = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROBE,
        S_RESULT
    } t_state;

    typedef struct packed {
        t_word key;
        t_word hash;
        t_word value;
    } t_slot;

    typedef struct packed {
        t_status status;
        t_word   value;
    } t_result;

    typedef struct packed {
        logic       rd_en;
        t_slot_addr rd_addr;
        logic       wr_en;
        t_slot_addr wr_addr;
        t_slot      wr_data;
    } t_mem_req;

endpackage

// ===== hdl/rhh_slot_mem.sv =====
module rhh_slot_mem (
    input  logic            i_clk,
    input  rhh_pkg::t_mem_req i_req,
    output rhh_pkg::t_slot  o_rd_data
);
    import rhh_pkg::*;

    t_slot r_mem [SLOTS];
    t_slot r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/rhh_probe_ctrl.sv =====
module rhh_probe_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  rhh_pkg::t_cmd                 i_command,
    input  rhh_pkg::t_word                i_key,
    input  rhh_pkg::t_word                i_hash_code,
    input  rhh_pkg::t_word                i_value,
    input  logic [rhh_pkg::FILL_BITS-1:0] i_fill_limit,
    output logic                          o_busy,
    output logic                          o_res_valid,
    output rhh_pkg::t_result              o_res,
    input  logic                          i_res_take,
    output rhh_pkg::t_mem_req             o_mem_req,
    input  rhh_pkg::t_slot                i_rd_data
);
    import rhh_pkg::*;

    t_state           r_state, n_state;
    t_cmd             r_cmd, n_cmd;
    t_slot            r_carry, n_carry;
    t_slot_addr       r_pos, n_pos;
    t_slot_addr       r_step, n_step;
    t_slot_addr       r_iter, n_iter;
    logic             r_orig, n_orig;
    logic [SLOTS-1:0] r_used;
    t_count           r_count, n_count;
    t_result          r_res, n_res;
    logic             set_used;

    t_slot_addr home_dist;
    logic       slot_used;
    logic       key_match;
    logic       is_full;

    assign slot_used = r_used[r_pos];
    assign home_dist = r_pos - i_rd_data.hash[SLOT_BITS-1:0];
    assign key_match = (i_rd_data.hash == r_carry.hash) && (i_rd_data.key == r_carry.key);
    assign is_full   = (CMP_BITS'(r_count) >= CMP_BITS'(i_fill_limit)) ||
                       (r_count >= COUNT_BITS'(SLOTS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (set_used) begin
                r_used[r_pos] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_carry <= n_carry;
        r_pos   <= n_pos;
        r_step  <= n_step;
        r_iter  <= n_iter;
        r_orig  <= n_orig;
        r_res   <= n_res;
    end

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_carry   = r_carry;
        n_pos     = r_pos;
        n_step    = r_step;
        n_iter    = r_iter;
        n_orig    = r_orig;
        n_count   = r_count;
        n_res     = r_res;
        set_used  = 1'b0;
        o_mem_req = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_cmd   = i_command;
                    n_carry = '{key: i_key, hash: i_hash_code, value: i_value};
                    n_pos   = i_hash_code[SLOT_BITS-1:0];
                    n_step  = '0;
                    n_iter  = '0;
                    n_orig  = 1'b1;
                    if (i_command == CMD_INSERT && is_full) begin
                        n_res   = '{status: ST_FULL, value: '0};
                        n_state = S_RESULT;
                    end else begin
                        o_mem_req.rd_en   = 1'b1;
                        o_mem_req.rd_addr = i_hash_code[SLOT_BITS-1:0];
                        n_state           = S_PROBE;
                    end
                end
            end
            S_PROBE: begin
                // slot data for r_pos arrives now; next slot is read in the same cycle
                n_pos             = r_pos + 1'b1;
                n_iter            = r_iter + 1'b1;
                n_step            = r_step + 1'b1;
                o_mem_req.rd_en   = 1'b1;
                o_mem_req.rd_addr = r_pos + 1'b1;
                o_mem_req.wr_addr = r_pos;
                n_state           = S_RESULT;
                if (r_cmd == CMD_INSERT) begin
                    if (!slot_used) begin
                        o_mem_req.wr_en   = 1'b1;
                        o_mem_req.wr_data = r_carry;
                        set_used          = 1'b1;
                        n_count           = r_count + 1'b1;
                        n_res             = '{status: ST_NEW, value: '0};
                    end else if (r_orig && key_match) begin
                        o_mem_req.wr_en   = 1'b1;
                        o_mem_req.wr_data = '{key: i_rd_data.key, hash: i_rd_data.hash,
                                              value: r_carry.value};
                        n_res             = '{status: ST_REPLACED, value: '0};
                    end else begin
                        if (home_dist < r_step) begin
                            // richer entry gives up its slot, carry it onward
                            o_mem_req.wr_en   = 1'b1;
                            o_mem_req.wr_data = r_carry;
                            n_carry           = i_rd_data;
                            n_step            = home_dist + 1'b1;
                            n_orig            = 1'b0;
                        end
                        n_res = '{status: ST_FULL, value: '0};
                        if (r_iter != t_slot_addr'(SLOTS - 1)) begin
                            n_state = S_PROBE;
                        end
                    end
                end else begin
                    if (!slot_used || r_step > home_dist) begin
                        n_res = '{status: ST_MISSING, value: '0};
                    end else if (key_match) begin
                        n_res = '{status: ST_FOUND, value: i_rd_data.value};
                    end else begin
                        n_res = '{status: ST_MISSING, value: '0};
                        if (r_iter != t_slot_addr'(SLOTS - 1)) begin
                            n_state = S_PROBE;
                        end
                    end
                end
            end
            S_RESULT: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_res_valid = (r_state == S_RESULT);
    assign o_res       = r_res;

endmodule

// ===== hdl/robin_hood_hash_table_unit.sv =====
// Robin Hood hash table, 256 slots, linear probing, one request at a time. The
// slots sit in one memory with a registered read; the probe walks one slot per
// cycle, reading the next slot while it writes any change to the current one.
// A request goes from accept through one probe step per slot to a result
// handoff that waits until the output register can take it; the input stalls
// until that handoff. An insert rejected as full skips the probe steps.
// Slot occupancy bits live in flip-flops and clear at reset, so the table is
// usable on the first cycle after reset. fill_limit may be written whenever the
// block is idle and takes effect on the next insert.
module robin_hood_hash_table_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_command,
    input  logic [31:0]                   i_key,
    input  logic [31:0]                   i_hash_code,
    input  logic [31:0]                   i_value,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [2:0]                    o_status,
    output logic [31:0]                   o_found_value,
    input  logic                          i_cfg_we,
    input  logic [rhh_pkg::FILL_BITS-1:0] i_cfg_data
);
    import rhh_pkg::*;

    logic [FILL_BITS-1:0] r_fill_limit;
    logic                 r_out_valid;
    t_result              r_out;
    logic                 busy;
    logic                 res_valid;
    t_result              res;
    logic                 res_take;
    t_mem_req             mem_req;
    t_slot                rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_limit <= FILL_LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_fill_limit <= i_cfg_data;
        end
    end

    // output register frees the controller while a result waits downstream
    assign res_take = res_valid && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out <= res;
        end
    end

    rhh_probe_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_in_valid && !busy),
        .i_command    (t_cmd'(i_command)),
        .i_key        (i_key),
        .i_hash_code  (i_hash_code),
        .i_value      (i_value),
        .i_fill_limit (r_fill_limit),
        .o_busy       (busy),
        .o_res_valid  (res_valid),
        .o_res        (res),
        .i_res_take   (res_take),
        .o_mem_req    (mem_req),
        .i_rd_data    (rd_data)
    );

    rhh_slot_mem u_mem (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    assign o_in_stall    = busy;
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out.status;
    assign o_found_value = r_out.value;

`ifndef NO_ASSERTIONS
    a_value_only_when_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_FOUND) |-> o_found_value == '0)
        else $error("found_value nonzero without a hit");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second transaction accepted during a probe");

    a_result_from_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared with no request in flight");
`endif

endmodule
